>>> design/b64sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character mapping functions for the base64
// stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // pad character '='
  localparam logic [7:0] PAD_CHAR = 8'd61;

  // register indexes
  localparam logic REG_DIRECTION = 1'b0;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // one finished group, handed from the front end to the back end
  typedef struct packed {
    logic [23:0] bits;       // group, msb first
    logic        dec;        // decode group: emit bytes, else characters
    logic [1:0]  enc_total;  // encode: characters past this index are '='
    logic [1:0]  last_idx;   // index of the final word of this group
    logic        last;       // group closes the message
  } job_t;

  // sextet to alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd97 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'd48 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // alphabet character to sextet, anything else maps to zero
  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'd65 && c <= 8'd90) begin
      v = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      v = c - 8'd97 + 8'd26;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      v = c - 8'd48 + 8'd52;
    end else if (c == 8'd43) begin
      v = 8'd62;
    end else if (c == 8'd47) begin
      v = 8'd63;
    end else begin
      v = 8'd0;
    end
    return v[5:0];
  endfunction

endpackage

>>> design/b64sc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_in_if
// Input stream channel: one raw byte or character per word.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

>>> design/b64sc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_out_if
// Output stream channel: one encoded character or decoded byte per word.
// ----------------------------------------------------------------------------
interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> design/b64sc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input words, gathers them into groups and pushes each finished
// group into the job queue.
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               dec,
  input  logic               clear,
  b64sc_in_if.sink           feed,
  input  logic               full,
  output logic               push,
  output b64sc_pkg::job_t    push_job
);
  import b64sc_pkg::*;

  logic [17:0] group_bits;
  logic [1:0]  group_fill;
  logic [1:0]  pad_count;

  logic        accept;
  logic        done;
  logic [5:0]  sext;
  logic [1:0]  pad_seen;
  logic [23:0] enc_bits;
  logic [1:0]  enc_total;
  logic [23:0] dec_bits;
  logic [1:0]  dec_cnt;
  logic [1:0]  dec_out;

  assign feed.ready = !full;
  assign accept     = feed.valid && feed.ready;

  // character classification
  always_comb begin
    sext     = char_to_sextet(feed.in_byte);
    pad_seen = pad_count;
    if (feed.in_byte == PAD_CHAR && pad_count < 2'd2) begin
      pad_seen = pad_count + 2'd1;
    end
  end

  // encode group alignment
  always_comb begin
    case (group_fill)
      2'd0: begin
        enc_bits  = {feed.in_byte, 16'h0000};
        enc_total = 2'd1;
      end
      2'd1: begin
        enc_bits  = {group_bits[7:0], feed.in_byte, 8'h00};
        enc_total = 2'd2;
      end
      default: begin
        enc_bits  = {group_bits[15:0], feed.in_byte};
        enc_total = 2'd3;
      end
    endcase
  end

  // decode group alignment and byte count
  always_comb begin
    case (group_fill)
      2'd0: begin
        dec_bits = {sext, 18'h00000};
        dec_cnt  = 2'd1;
      end
      2'd1: begin
        dec_bits = {group_bits[5:0], sext, 12'h000};
        dec_cnt  = 2'd1;
      end
      2'd2: begin
        dec_bits = {group_bits[11:0], sext, 6'h00};
        dec_cnt  = 2'd2;
      end
      default: begin
        dec_bits = {group_bits, sext};
        dec_cnt  = 2'd3;
      end
    endcase
    dec_out = (dec_cnt > pad_seen) ? dec_cnt - pad_seen : 2'd1;
  end

  // group close and job build
  always_comb begin
    if (dec) begin
      done               = (group_fill == 2'd3) || feed.in_last;
      push_job.bits      = dec_bits;
      push_job.dec       = DIR_DECODE;
      push_job.enc_total = 2'd0;
      push_job.last_idx  = dec_out - 2'd1;
    end else begin
      done               = (group_fill >= 2'd2) || feed.in_last;
      push_job.bits      = enc_bits;
      push_job.dec       = DIR_ENCODE;
      push_job.enc_total = enc_total;
      push_job.last_idx  = 2'd3;
    end
    push_job.last = feed.in_last;
    push          = accept && done;
  end

  // group state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      group_bits <= '0;
      group_fill <= '0;
      pad_count  <= '0;
    end else if (accept) begin
      if (done) begin
        group_bits <= '0;
        group_fill <= '0;
        pad_count  <= '0;
      end else begin
        group_bits <= dec ? {group_bits[11:0], sext} : {group_bits[9:0], feed.in_byte};
        group_fill <= group_fill + 2'd1;
        pad_count  <= dec ? pad_seen : 2'd0;
      end
    end
  end

  // encode groups hold at most two bytes and never count padding
  a_enc_fill: assert property (@(posedge clk) disable iff (rst)
    !dec |-> (group_fill != 2'd3 && pad_count == 2'd0))
    else $error("encode group state out of range");

  // padding count saturates at two
  a_pad_sat: assert property (@(posedge clk) disable iff (rst)
    pad_count != 2'd3)
    else $error("pad count overflow");

endmodule

>>> design/b64sc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b64sc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64sc_pkg::job_t    push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output b64sc_pkg::job_t    head
);
  import b64sc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push |-> !full) and (pop |-> head_valid))
    else $error("job queue overrun or underrun");

endmodule

>>> design/b64sc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the head job into a registered output stage, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  b64sc_pkg::job_t    head,
  output logic               pop,
  b64sc_out_if.source        emit
);
  import b64sc_pkg::*;

  logic       obuf_valid;
  logic [7:0] obuf_byte;
  logic       obuf_last;
  logic [1:0] idx;

  logic       load;
  logic [5:0] sext;
  logic [7:0] dec_byte;
  logic [7:0] word;

  assign emit.valid    = obuf_valid;
  assign emit.out_byte = obuf_byte;
  assign emit.out_last = obuf_last;

  assign load = head_valid && (!obuf_valid || emit.ready);
  assign pop  = load && (idx == head.last_idx);

  // pick the current sextet or byte of the group
  always_comb begin
    case (idx)
      2'd0: begin
        sext     = head.bits[23:18];
        dec_byte = head.bits[23:16];
      end
      2'd1: begin
        sext     = head.bits[17:12];
        dec_byte = head.bits[15:8];
      end
      2'd2: begin
        sext     = head.bits[11:6];
        dec_byte = head.bits[7:0];
      end
      default: begin
        sext     = head.bits[5:0];
        dec_byte = head.bits[7:0];
      end
    endcase
    if (head.dec) begin
      word = dec_byte;
    end else if (idx <= head.enc_total) begin
      word = sextet_to_char(sext);
    end else begin
      word = PAD_CHAR;
    end
  end

  // word index within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= pop ? 2'd0 : idx + 2'd1;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (load) begin
      obuf_valid <= 1'b1;
    end else if (emit.ready) begin
      obuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_byte <= word;
      obuf_last <= head.last && (idx == head.last_idx);
    end
  end

  // the word index never runs past the head job
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("word index past end of job");

endmodule

>>> design/base64_stream_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec
// Byte-wide base64 encoder and decoder with an APB-style direction register.
// ----------------------------------------------------------------------------
// path: a group's job enters the queue, then its words enter the output register
// throughput: one input word per cycle unless the queue is full; the single
//   output stage drives one word per cycle unless stalled, so encoding is
//   bound by the output side, which emits four characters per three bytes
// reset: rst selects encode and clears the open group, the job queue and
//   the output stage; a direction write also drops any open group
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  b64sc_in_if.sink    feed,
  b64sc_out_if.source emit
);
  import b64sc_pkg::*;

  logic direction;
  logic cfg_write;
  logic push;
  logic pop;
  logic full;
  logic head_valid;
  job_t push_job;
  job_t head;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
  assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_write) begin
      direction <= pwdata[0];
    end
  end

  // front end: gathers groups
  b64sc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dec      (direction),
    .clear    (cfg_write),
    .feed     (feed),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: emits words
  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .emit       (emit)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream codec. A behavioral model of the
// encoder and decoder predicts every output word from the accepted input
// words and the direction register. The output monitor compares each word
// with the oldest prediction. Directed groups come first, then random
// messages in both directions, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import b64sc_pkg::*;

  localparam logic [8*64-1:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                          "abcdefghijklmnopqrstuvwxyz",
                                          "0123456789+/"};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        sink_ready = 1'b0;

  b64sc_in_if  feed_if ();
  b64sc_out_if emit_if ();

  assign emit_if.ready = sink_ready;

  base64_stream_codec i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .feed    (feed_if),
    .emit    (emit_if)
  );

  // model state of the codec
  logic        mode;
  logic [17:0] grp_bits;
  logic [1:0]  grp_fill;
  logic [1:0]  pad_seen;

  out_word_t expected_words[$];
  int        errors = 0;
  int        items_sent = 0;
  bit        idle_on = 1'b1;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // alphabet lookups
  function automatic logic [7:0] char_of(input logic [5:0] s);
    return ALPHABET[8 * (63 - s) +: 8];
  endfunction

  function automatic logic [5:0] sextet_of_char(input logic [7:0] c);
    logic [5:0] v;
    v = '0;
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[8 * (63 - i) +: 8] == c) v = 6'(i);
    end
    return v;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_fill = '0;
    pad_seen = '0;
  endfunction

  // advance the model by one input word, queue the words it produces
  function automatic void codec_predict(input logic [7:0] b, input logic l);
    logic [23:0] bits;
    logic [5:0]  v;
    int          total;
    int          cnt;
    out_word_t   w;
    if (mode == DIR_ENCODE) begin
      if (grp_fill >= 2 || l) begin
        total = grp_fill + 1;
        bits = {grp_bits[15:0], b} << (8 * (3 - total));
        for (int k = 0; k < 4; k++) begin
          w.data = (k <= total) ? char_of(bits[23 - 6 * k -: 6]) : PAD_CHAR;
          w.last = l && (k == 3);
          expected_words.push_back(w);
        end
        clear_group();
      end else begin
        grp_bits = {grp_bits[9:0], b};
        grp_fill++;
      end
    end else begin
      v = sextet_of_char(b);
      // padding counts wherever it stands, saturating at two
      if (b == PAD_CHAR && pad_seen < 2) pad_seen++;
      if (grp_fill >= 3 || l) begin
        total = grp_fill + 1;
        bits = {grp_bits, v} << (6 * (4 - total));
        if (total == 4) cnt = 3;
        else if (total == 1) cnt = 1;
        else cnt = total - 1;
        cnt = (cnt > pad_seen) ? cnt - pad_seen : 1;
        for (int k = 0; k < cnt; k++) begin
          w.data = bits[23 - 8 * k -: 8];
          w.last = l && (k == cnt - 1);
          expected_words.push_back(w);
        end
        clear_group();
      end else begin
        grp_bits = {grp_bits[11:0], v};
        grp_fill++;
      end
    end
  endfunction

  // output side stalls
  always @(posedge clk) begin
    sink_ready <= idle_on ? ($urandom_range(99) >= 32) : 1'b1;
  end

  // output word checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && emit_if.valid && emit_if.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual byte %h last %b",
                 $time, emit_if.out_byte, emit_if.out_last);
      end else begin
        want = expected_words.pop_front();
        if (emit_if.out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, want.data, emit_if.out_byte);
        end
        if (emit_if.out_last !== want.last) begin
          errors++;
          $display("%0t: out_last mismatch, expected %b, actual %b",
                   $time, want.last, emit_if.out_last);
        end
      end
    end
  end

  // send one input word, at times with a random gap in front
  task automatic send_word(input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(99) < 32) begin
      feed_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    feed_if.valid   <= 1'b1;
    feed_if.in_byte <= b;
    feed_if.in_last <= l;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    codec_predict(b, l);
    items_sent++;
  endtask

  task automatic send_chars(input string s, input bit close_msg);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], close_msg && (i == s.len() - 1));
    end
  endtask

  // stop sending and let every predicted word come out
  task automatic wait_drained();
    feed_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write the direction register while idle, then read it back
  task automatic set_direction(input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DIRECTION, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mode = value[0];
    clear_group();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, mode}) begin
      errors++;
      $display("%0t: prdata mismatch, expected %h, actual %h",
               $time, {31'b0, mode}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random raw message, last flag on the final byte
  task automatic send_encode_msg();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      send_word(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // random base64 message: mostly well formed, some short tails and noise
  task automatic send_decode_msg();
    int         n_chars;
    int         pads;
    int         shape;
    logic [7:0] c;
    n_chars = 4 * $urandom_range(1, 4);
    shape = $urandom_range(9);
    pads = 0;
    if (shape < 6) pads = $urandom_range(0, 2);
    else if (shape < 8) n_chars = n_chars - $urandom_range(1, 3);
    else pads = $urandom_range(0, 3);
    for (int i = 0; i < n_chars; i++) begin
      if (i >= n_chars - pads) c = PAD_CHAR;
      else if (shape >= 8 || $urandom_range(19) == 0) c = 8'($urandom_range(255));
      else c = char_of(6'($urandom_range(63)));
      send_word(c, i == n_chars - 1);
    end
  endtask

  // encode from the reset direction: full groups, both flush lengths, extremes
  task automatic test_encode_directed();
    send_chars("Man", 1'b0);
    send_chars("Ma", 1'b1);
    send_chars("M", 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  // decode: all character classes, padding, invalid codes, short tails,
  // and an open group dropped by a register write
  task automatic test_decode_directed();
    set_direction({31'b0, DIR_DECODE});
    send_chars("9+/z", 1'b0);
    send_chars("TQ==", 1'b1);
    send_word(PAD_CHAR, 1'b0);
    send_word(8'hFF, 1'b1);
    send_chars("A", 1'b1);
    send_chars("zz", 1'b0);
    set_direction({31'b0, DIR_DECODE});
    send_chars("TWE", 1'b1);
  endtask

  task automatic test_random_encode();
    int start;
    set_direction({31'b0, DIR_ENCODE});
    start = items_sent;
    while (items_sent - start < 100) begin
      send_encode_msg();
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  task automatic test_random_decode();
    int start;
    set_direction({31'b0, DIR_DECODE});
    start = items_sent;
    while (items_sent - start < 110) begin
      send_decode_msg();
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  // back to back traffic with no stalls on either side
  task automatic test_burst();
    int start;
    idle_on = 1'b0;
    set_direction({31'b0, DIR_ENCODE});
    start = items_sent;
    while (items_sent - start < 30) send_encode_msg();
    set_direction({31'b0, DIR_DECODE});
    start = items_sent;
    while (items_sent - start < 30) send_decode_msg();
    idle_on = 1'b1;
  endtask

  // direction changes between messages, random upper data bits
  task automatic test_mixed_direction();
    int          start;
    logic [31:0] value;
    start = items_sent;
    while (items_sent - start < 70) begin
      value = $urandom;
      set_direction(value);
      if (value[0] == DIR_ENCODE) send_encode_msg();
      else send_decode_msg();
    end
  endtask

  initial begin
    feed_if.valid   <= 1'b0;
    feed_if.in_byte <= '0;
    feed_if.in_last <= 1'b0;
    mode = DIR_ENCODE;
    clear_group();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_encode_directed();
    test_decode_directed();
    test_random_encode();
    test_random_decode();
    test_burst();
    test_mixed_direction();
    wait_drained();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
design/b64sc_pkg.sv
design/b64sc_in_if.sv
design/b64sc_out_if.sv
design/b64sc_front.sv
design/b64sc_queue.sv
design/b64sc_back.sv
design/base64_stream_codec.sv
tb/tb_top.sv
